### src/pdfe_pkg.sv
// ----------------------------------------------------------------------------
// pdfe_pkg: shared types and constants for the Pelco-D register frame encoder
// Transaction structs, microcode word layout, register map and frame codes.
// ----------------------------------------------------------------------------
package pdfe_pkg;

  localparam int unsigned REG_COUNT_DEF = 128;
  // wide enough to hold any register index and REG_COUNT itself (max 256)
  localparam int unsigned ADDR_XW       = 9;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned UADDR_W       = 5;

  // register map
  localparam logic [6:0] RG_CMD       = 7'h00;
  localparam logic [6:0] RG_RAW_LAST  = 7'h14;
  localparam logic [4:0] RG_ADDR      = 5'h02;
  localparam logic [4:0] RG_SPEED     = 5'h03;
  localparam logic [4:0] RG_ARG       = 5'h04;
  localparam logic [4:0] RG_RAW_FIRST = 5'h0E;

  // frame bytes
  localparam logic [7:0] FR_SYNC      = 8'hFF;
  localparam logic [7:0] FR_ZERO      = 8'h00;
  localparam logic [7:0] CB_STOP      = 8'h00;
  localparam logic [7:0] CB_RIGHT     = 8'h02;
  localparam logic [7:0] CB_LEFT      = 8'h04;
  localparam logic [7:0] CB_UP        = 8'h08;
  localparam logic [7:0] CB_DOWN      = 8'h10;
  localparam logic [7:0] CB_SET_PRE   = 8'h03;
  localparam logic [7:0] CB_CLR_PRE   = 8'h05;
  localparam logic [7:0] CB_GOTO_PRE  = 8'h07;
  localparam logic [7:0] CB_RESET     = 8'h0F;
  localparam logic [7:0] CB_PAN_QRY   = 8'h51;
  localparam logic [7:0] CB_TILT_QRY  = 8'h53;
  localparam logic [7:0] CB_SET_ZERO  = 8'h49;
  localparam logic [7:0] ARG_FLIP     = 8'd21;
  localparam logic [7:0] ARG_ZERO_PAN = 8'd22;

  // written command codes
  localparam logic [7:0] OP_RIGHT     = 8'd1;
  localparam logic [7:0] OP_LEFT      = 8'd2;
  localparam logic [7:0] OP_UP        = 8'd3;
  localparam logic [7:0] OP_DOWN      = 8'd4;
  localparam logic [7:0] OP_SET_PRE   = 8'd5;
  localparam logic [7:0] OP_CLR_PRE   = 8'd6;
  localparam logic [7:0] OP_GOTO_PRE  = 8'd7;
  localparam logic [7:0] OP_FLIP      = 8'd8;
  localparam logic [7:0] OP_ZERO_PAN  = 8'd9;
  localparam logic [7:0] OP_RESET     = 8'd10;
  localparam logic [7:0] OP_PAN_QRY   = 8'd11;
  localparam logic [7:0] OP_TILT_QRY  = 8'd12;
  localparam logic [7:0] OP_SET_ZERO  = 8'd13;

  // microcode entry points
  localparam logic [STEP_W-1:0] ST_RAW = 5'd12;
  localparam logic [STEP_W-1:0] ST_RD  = 5'd20;
  localparam logic [STEP_W-1:0] ST_END = 5'd21;

  typedef struct packed {
    logic       command;
    logic [6:0] reg_addr;
    logic [7:0] write_data;
  } pdfe_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } pdfe_out_t;

  typedef enum logic [2:0] {
    SRC_SYNC = 3'd0,
    SRC_ZERO = 3'd1,
    SRC_MEM  = 3'd2,
    SRC_CMD  = 3'd3,
    SRC_D4   = 3'd4,
    SRC_D5   = 3'd5,
    SRC_SUM  = 3'd6
  } src_e;

  typedef enum logic [1:0] {
    J_NONE    = 2'd0,
    J_READ    = 2'd1,
    J_RAW     = 2'd2,
    J_NOT_CMD = 2'd3
  } jcond_e;

  typedef enum logic {
    RD_ITEM  = 1'b0,
    RD_CONST = 1'b1
  } rdsel_e;

  typedef struct packed {
    logic                emit;
    logic                kind;
    logic                last;
    src_e                src;
    logic                add;
    logic                ld_arg;
    logic                ld_spd;
    logic                rd_en;
    rdsel_e              rd_sel;
    logic [UADDR_W-1:0]  rd_addr;
    logic                wr;
    jcond_e              cond;
    logic [STEP_W-1:0]   target;
    logic                done;
  } ucw_t;

  typedef struct packed {
    logic is_read;
    logic is_cmd;
    logic is_raw;
  } pdfe_flags_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] d4;
    logic [7:0] d5;
  } pdfe_cmd_t;

  // power-on contents of registers 0..12, rest zero
  function automatic logic [7:0] pdfe_reset_val(input logic [7:0] idx);
    logic [7:0] v;
    case (idx)
      8'd0:    v = 8'h04;
      8'd1:    v = 8'h11;
      8'd2:    v = 8'h01;
      8'd3:    v = 8'hFF;
      8'd8:    v = 8'h04;
      8'd9:    v = 8'h04;
      8'd10:   v = 8'h01;
      8'd11:   v = 8'h02;
      8'd12:   v = 8'h06;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // command code -> command byte and the two data bytes
  function automatic pdfe_cmd_t pdfe_decode(input logic [7:0] code,
                                           input logic [7:0] spd,
                                           input logic [7:0] arg);
    pdfe_cmd_t r;
    r = '{cmd: CB_STOP, d4: FR_ZERO, d5: FR_ZERO};
    case (code)
      OP_RIGHT:    r = '{cmd: CB_RIGHT,    d4: spd,     d5: spd};
      OP_LEFT:     r = '{cmd: CB_LEFT,     d4: spd,     d5: spd};
      OP_UP:       r = '{cmd: CB_UP,       d4: spd,     d5: spd};
      OP_DOWN:     r = '{cmd: CB_DOWN,     d4: spd,     d5: spd};
      OP_SET_PRE:  r = '{cmd: CB_SET_PRE,  d4: FR_ZERO, d5: arg};
      OP_CLR_PRE:  r = '{cmd: CB_CLR_PRE,  d4: FR_ZERO, d5: arg};
      OP_GOTO_PRE: r = '{cmd: CB_GOTO_PRE, d4: FR_ZERO, d5: arg};
      OP_FLIP:     r = '{cmd: CB_GOTO_PRE, d4: FR_ZERO, d5: ARG_FLIP};
      OP_ZERO_PAN: r = '{cmd: CB_GOTO_PRE, d4: FR_ZERO, d5: ARG_ZERO_PAN};
      OP_RESET:    r = '{cmd: CB_RESET,    d4: FR_ZERO, d5: FR_ZERO};
      OP_PAN_QRY:  r = '{cmd: CB_PAN_QRY,  d4: FR_ZERO, d5: FR_ZERO};
      OP_TILT_QRY: r = '{cmd: CB_TILT_QRY, d4: FR_ZERO, d5: FR_ZERO};
      OP_SET_ZERO: r = '{cmd: CB_SET_ZERO, d4: FR_ZERO, d5: FR_ZERO};
      default:     r = '{cmd: CB_STOP,     d4: spd,     d5: spd};
    endcase
    return r;
  endfunction

endpackage

### src/pelco_d_register_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// pelco_d_register_frame_encoder_top: Pelco-D register frame encoder
// Byte register file with read/write access; command writes emit frames.
// ----------------------------------------------------------------------------
// One input transaction is a register read or write. A read returns one
// result (kind 0, last 1); a read beyond REG_COUNT returns 0. A write stores
// the byte; a write to register 0 also emits a 7-byte Pelco-D frame
// (sync, address from reg 2, 0x00, command byte, two data bytes, checksum of
// bytes 1..5), a write to register 0x14 emits registers 0x0E..0x14 as they
// stand, and any other write emits nothing. One transaction is handled at a
// time. After the accept cycle a microcode sequencer runs: 2 steps for a
// read, 4 for a plain write, 12 for a command frame and 10 for a raw frame,
// and an emit step holds while the full output register waits on out_ready_i.
// The single read port of the register memory sets these counts: each
// register byte is fetched in its own step and its read data is registered.
// The final result sits in an output register, so the next transaction is
// accepted while it waits. The register file is a memory with per-entry
// valid bits; an entry never written reads as its power-on value.
// ----------------------------------------------------------------------------
module pelco_d_register_frame_encoder_top import pdfe_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pdfe_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pdfe_out_t out_data_o
);

  localparam int unsigned AW = $clog2(REG_COUNT);

  // --- accepted transaction ------------------------------------------------
  pdfe_in_t    item_q;
  logic        item_oor;
  pdfe_flags_t flags;
  logic        in_fire;

  logic  busy, go;
  ucw_t  cw;
  logic  out_blocked;

  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
  end

  // index beyond the bank: write ignored, read gives 0
  assign item_oor      = {2'b00, item_q.reg_addr} >= ADDR_XW'(REG_COUNT);
  assign flags.is_read = !item_q.command;
  assign flags.is_cmd  = item_q.reg_addr == RG_CMD;
  assign flags.is_raw  = item_q.reg_addr == RG_RAW_LAST;

  pdfe_useq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_fire),
    .flags_i       (flags),
    .out_blocked_i (out_blocked),
    .busy_o        (busy),
    .go_o          (go),
    .cw_o          (cw)
  );

  // --- register file -------------------------------------------------------
  logic [7:0]         mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [ADDR_XW-1:0] wr_addr9, rd_addr9;
  logic [AW-1:0]      wr_idx, rd_idx;
  logic               wr_en, rd_en;
  logic [7:0]         rd_data_q, rd_dflt_q;
  logic               rd_vld_q, rd_oor_q;
  logic [7:0]         rd_val;

  assign wr_addr9 = {2'b00, item_q.reg_addr};
  assign wr_idx   = wr_addr9[AW-1:0];
  assign rd_addr9 = (cw.rd_sel == RD_ITEM) ? wr_addr9
                                            : {{(ADDR_XW-UADDR_W){1'b0}}, cw.rd_addr};
  assign rd_idx   = rd_addr9[AW-1:0];
  assign wr_en    = go && cw.wr && !item_oor;
  assign rd_en    = go && cw.rd_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= item_q.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx];
      rd_vld_q  <= vld_q[rd_idx];
      rd_dflt_q <= pdfe_reset_val(rd_addr9[7:0]);
      rd_oor_q  <= (cw.rd_sel == RD_ITEM) && item_oor;
    end
  end

  assign rd_val = rd_oor_q ? 8'h00 : (rd_vld_q ? rd_data_q : rd_dflt_q);

  // --- frame datapath ------------------------------------------------------
  logic [7:0] arg_q, spd_q, sum_q;
  pdfe_cmd_t  dec;
  logic [7:0] byte_out;

  assign dec = pdfe_decode(item_q.write_data, spd_q, arg_q);

  always_comb begin
    case (cw.src)
      SRC_SYNC: byte_out = FR_SYNC;
      SRC_ZERO: byte_out = FR_ZERO;
      SRC_MEM:  byte_out = rd_val;
      SRC_CMD:  byte_out = dec.cmd;
      SRC_D4:   byte_out = dec.d4;
      SRC_D5:   byte_out = dec.d5;
      SRC_SUM:  byte_out = sum_q;
      default:  byte_out = FR_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (go && cw.ld_arg) begin
      arg_q <= rd_val;
    end
    if (go && cw.ld_spd) begin
      spd_q <= rd_val;
    end
    // checksum wraps modulo 256
    if (in_fire) begin
      sum_q <= 8'h00;
    end else if (go && cw.add) begin
      sum_q <= sum_q + byte_out;
    end
  end

  // --- output register -----------------------------------------------------
  logic      out_valid_q, out_valid_d;
  pdfe_out_t out_q;
  logic      emit_go;

  assign out_blocked = out_valid_q && !out_ready_i;
  assign emit_go     = go && cw.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= '{kind: cw.kind, data: byte_out, last: cw.last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // an emit never overwrites an undelivered transaction
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before delivery");
  // a read result is always the last of its access
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind |-> out_data_o.last)
    else $error("read result without last");
  // out-of-range writes never reach the register file
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !item_oor && item_q.command)
    else $error("illegal register file write");
  // an accepted transaction starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy && !in_ready_o)
    else $error("accepted transaction did not start the sequencer");
`endif

endmodule

### src/pdfe_useq.sv
// ----------------------------------------------------------------------------
// pdfe_useq: microcode sequencer
// Step counter, control-store ROM and conditional jumps; stalls emit steps
// while the output register is full and out_ready_i is low.
// ----------------------------------------------------------------------------
module pdfe_useq import pdfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  pdfe_flags_t flags_i,
  input  logic        out_blocked_i,
  output logic        busy_o,
  output logic        go_o,
  output ucw_t        cw_o
);

  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    w.kind = 1'b1;
    case (step)
      5'd0: begin
        w.cond = J_READ; w.target = ST_RD; w.rd_en = 1'b1; w.rd_sel = RD_ITEM;
      end
      5'd1: begin
        w.wr = 1'b1; w.cond = J_RAW; w.target = ST_RAW;
      end
      5'd2: begin
        w.cond = J_NOT_CMD; w.target = ST_END;
        w.rd_en = 1'b1; w.rd_sel = RD_CONST; w.rd_addr = RG_ARG;
      end
      5'd3: begin
        w.ld_arg = 1'b1; w.rd_en = 1'b1; w.rd_sel = RD_CONST; w.rd_addr = RG_SPEED;
      end
      5'd4: begin
        w.ld_spd = 1'b1; w.rd_en = 1'b1; w.rd_sel = RD_CONST; w.rd_addr = RG_ADDR;
      end
      5'd5:  begin w.emit = 1'b1; w.src = SRC_SYNC; end
      5'd6:  begin w.emit = 1'b1; w.src = SRC_MEM;  w.add = 1'b1; end
      5'd7:  begin w.emit = 1'b1; w.src = SRC_ZERO; end
      5'd8:  begin w.emit = 1'b1; w.src = SRC_CMD;  w.add = 1'b1; end
      5'd9:  begin w.emit = 1'b1; w.src = SRC_D4;   w.add = 1'b1; end
      5'd10: begin w.emit = 1'b1; w.src = SRC_D5;   w.add = 1'b1; end
      5'd11: begin w.emit = 1'b1; w.src = SRC_SUM;  w.last = 1'b1; w.done = 1'b1; end
      5'd12: begin
        w.rd_en = 1'b1; w.rd_sel = RD_CONST; w.rd_addr = RG_RAW_FIRST;
      end
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18: begin
        // emit previous raw byte while fetching the next one
        w.emit = 1'b1; w.src = SRC_MEM;
        w.rd_en = 1'b1; w.rd_sel = RD_CONST;
        w.rd_addr = RG_RAW_FIRST + (step - ST_RAW);
      end
      5'd19: begin w.emit = 1'b1; w.src = SRC_MEM; w.last = 1'b1; w.done = 1'b1; end
      5'd20: begin
        w.emit = 1'b1; w.kind = 1'b0; w.src = SRC_MEM; w.last = 1'b1; w.done = 1'b1;
      end
      default: begin w.done = 1'b1; end
    endcase
    return w;
  endfunction

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              jump;

  assign cw_o   = ucode(step_q);
  assign busy_o = busy_q;
  assign go_o   = busy_q && !(cw_o.emit && out_blocked_i);

  always_comb begin
    case (cw_o.cond)
      J_READ:    jump = flags_i.is_read;
      J_RAW:     jump = flags_i.is_raw;
      J_NOT_CMD: jump = !flags_i.is_cmd;
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (go_o) begin
      if (cw_o.done) begin
        busy_d = 1'b0;
      end else if (jump) begin
        step_d = cw_o.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

`ifndef NO_ASSERTIONS
  // the sequencer only leaves idle through a start
  a_start_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !start_i |=> !busy_q)
    else $error("sequencer went busy without a start");
  // a stalled emit step holds its place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !go_o |=> busy_q && step_q == $past(step_q))
    else $error("sequencer moved during a stall");
  // the final step of every program is an emit or the end step
  a_done_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_o && cw_o.done |-> cw_o.emit || step_q == ST_END)
    else $error("program ended on a silent step");
`endif

endmodule
